@@ hdl/vmbe_pkg.sv @@
// Package for the variable-length byte encoder: item kinds, marker codes, widths and types.
// Used by vmbe_digit, vmbe_obuf, the top level and the testbench; depends on nothing else.
package vmbe_pkg;

    localparam int VALUE_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int GROUP_BITS = 7;
    localparam int KIND_W     = 2;

    localparam logic [BYTE_W-1:0] MARK_NOT_FOUND = 8'h40;
    localparam logic [BYTE_W-1:0] MARK_INVALID   = 8'h41;
    localparam logic [BYTE_W-1:0] MARK_END_SEQ   = 8'h42;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE     = 2'd0,
        KIND_NOT_FOUND = 2'd1,
        KIND_INVALID   = 2'd2,
        KIND_END_SEQ   = 2'd3
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_beat;

    function automatic logic [BYTE_W-1:0] f_marker(input t_kind kind);
        logic [BYTE_W-1:0] code;
        case (kind)
            KIND_NOT_FOUND: code = MARK_NOT_FOUND;
            KIND_INVALID:   code = MARK_INVALID;
            default:        code = MARK_END_SEQ;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/vmbe_digit.sv @@
// Group shifter of the encoder: loads one item and emits one 7-bit group per beat.
// Depends on vmbe_pkg.
module vmbe_digit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load_valid,
    output logic                          o_load_ready,
    input  vmbe_pkg::t_kind               i_kind,
    input  logic [vmbe_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_beat_valid,
    input  logic                          i_beat_ready,
    output vmbe_pkg::t_beat               o_beat
);
    import vmbe_pkg::*;

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_sr, n_sr;
    logic                 r_mark, n_mark;
    logic                 w_final;

    assign w_final      = r_mark || (r_sr[VALUE_W-1:GROUP_BITS-1] == '0);
    assign o_beat.data  = {~w_final, r_sr[GROUP_BITS-1:0]};
    assign o_beat.last  = w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sr   <= n_sr;
        r_mark <= n_mark;
    end

    always_comb begin
        n_state      = r_state;
        n_sr         = r_sr;
        n_mark       = r_mark;
        o_load_ready = 1'b0;
        o_beat_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_load_ready = 1'b1;
                if (i_load_valid) begin
                    n_state = ST_EMIT;
                    if (i_kind == KIND_VALUE) begin
                        n_sr   = i_value;
                        n_mark = 1'b0;
                    end else begin
                        n_sr   = {{(VALUE_W-BYTE_W){1'b0}}, f_marker(i_kind)};
                        n_mark = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                o_beat_valid = 1'b1;
                if (i_beat_ready) begin
                    if (w_final) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_sr = {{GROUP_BITS{1'b0}}, r_sr[VALUE_W-1:GROUP_BITS]};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/vmbe_obuf.sv @@
// Output register of the encoder: holds one beat; ready while empty or while i_ready is high.
// Depends on vmbe_pkg.
module vmbe_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vmbe_pkg::t_beat i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output vmbe_pkg::t_beat o_beat
);
    import vmbe_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

@@ hdl/varint_marker_byte_encoder.sv @@
// Top level of the variable-length byte encoder for values and markers.
// Depends on vmbe_pkg, vmbe_digit and vmbe_obuf.
//
// The slave channel takes one item per beat: tuser holds the kind and tdata the
// 64-bit value. A value is sent as little-endian 7-bit groups, one byte per beat
// on the master channel, bit 7 set on every byte but the last; a marker kind gives
// the single byte 0x40, 0x41 or 0x42. tlast marks the final byte of each item.
// The first byte of an item is registered in the group shifter and then in the
// output register before it is shown on the master channel. An item giving N
// bytes (1 to 10) is loaded in the shifter's idle state and then emitted in its
// emit state, one byte per beat. The shifter handles one item at a time and
// drops tready while it emits; a one-beat output register lets it load the next
// item while the last byte of the previous one still waits to be taken.
// When the receiver stalls, the output register holds its beat and the shifter
// waits with its current group. Reset empties the output register and returns
// the shifter to idle; no beat is lost or repeated across a stall.
module varint_marker_byte_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [vmbe_pkg::VALUE_W-1:0]  i_s_axis_tdata,  // [63:0] value
    input  logic [vmbe_pkg::KIND_W-1:0]   i_s_axis_tuser,  // [1:0] kind
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [vmbe_pkg::BYTE_W-1:0]   o_m_axis_tdata,  // [7:0] out_byte
    output logic                          o_m_axis_tlast
);
    import vmbe_pkg::*;

    logic  w_beat_valid;
    logic  w_beat_ready;
    t_beat w_beat;
    t_beat w_out_beat;

    vmbe_digit u_digit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (i_s_axis_tvalid),
        .o_load_ready (o_s_axis_tready),
        .i_kind       (t_kind'(i_s_axis_tuser)),
        .i_value      (i_s_axis_tdata),
        .o_beat_valid (w_beat_valid),
        .i_beat_ready (w_beat_ready),
        .o_beat       (w_beat)
    );

    vmbe_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_beat_valid),
        .o_ready (w_beat_ready),
        .i_beat  (w_beat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_beat  (w_out_beat)
    );

    assign o_m_axis_tdata = w_out_beat.data;
    assign o_m_axis_tlast = w_out_beat.last;

endmodule

@@ hdl/vmbe_checker.sv @@
// Port-level checks for the variable-length byte encoder, bound to its top level.
// Depends only on the ports of varint_marker_byte_encoder.
module vmbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("Stalled output beat changed.");

    a_cont_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7] == !o_m_axis_tlast))
        else $error("Continuation bit disagrees with tlast.");

    a_bit6_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast && o_m_axis_tdata[6] |->
            (o_m_axis_tdata == 8'h40 || o_m_axis_tdata == 8'h41
             || o_m_axis_tdata == 8'h42))
        else $error("Final byte with bit 6 set is not a marker.");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("Input accepted while an item is being encoded.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid straight after reset.");

endmodule

bind varint_marker_byte_encoder vmbe_checker u_vmbe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for varint_marker_byte_encoder: values and markers go in as beats,
// and every output byte is compared with a local encoder model. Depends on vmbe_pkg and the RTL.
module tb_top;
    import vmbe_pkg::*;

    typedef struct {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
    } t_enc_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic                m_tlast;

    t_enc_item enc_items_q[$];
    t_beat     exp_bytes_q[$];
    t_enc_item cur_item;

    int errors = 0;
    int items_total = 0;
    int items_taken = 0;
    int markers_taken = 0;
    int ten_byte_values = 0;
    int bytes_checked = 0;
    int src_gap = 0;
    int src_calm = 0;
    int snk_stall = 0;
    int snk_calm = 0;

    varint_marker_byte_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        int len;
        logic [VALUE_W-1:0] v;
        len = $urandom_range(VALUE_W);
        v = {$urandom, $urandom};
        if (len == 0) begin
            v = '0;
        end else begin
            v = v >> (VALUE_W - len);
            v[len-1] = 1'b1;
        end
        return v;
    endfunction

    task automatic add_item(input t_kind kind, input logic [VALUE_W-1:0] value);
        t_enc_item it;
        it.kind = kind;
        it.value = value;
        enc_items_q.push_back(it);
    endtask

    // Appends the bytes that one accepted item must produce.
    task automatic predict_varint(input t_enc_item it);
        t_beat b;
        logic [VALUE_W-1:0] rest;
        int nbits;
        int ngroups;
        if (it.kind != KIND_VALUE) begin
            case (it.kind)
                KIND_NOT_FOUND: b.data = MARK_NOT_FOUND;
                KIND_INVALID:   b.data = MARK_INVALID;
                default:        b.data = MARK_END_SEQ;
            endcase
            b.last = 1'b1;
            exp_bytes_q.push_back(b);
            markers_taken++;
        end else begin
            nbits = 0;
            rest = it.value;
            while (rest != 0) begin
                nbits++;
                rest = rest >> 1;
            end
            ngroups = nbits / GROUP_BITS + 1;
            if (ngroups == 10) begin
                ten_byte_values++;
            end
            rest = it.value;
            for (int i = 0; i < ngroups; i++) begin
                b.last = (i == ngroups - 1);
                b.data = {~b.last, rest[6:0]};
                exp_bytes_q.push_back(b);
                rest = rest >> GROUP_BITS;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_varint(cur_item);
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (enc_items_q.size() > 0) begin
                    cur_item = enc_items_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_item.value;
                    s_tuser <= cur_item.kind;
                    if (src_calm > 0) begin
                        src_calm--;
                    end else begin
                        src_gap = pick_idle();
                        if ($urandom_range(19) == 0) begin
                            src_calm = $urandom_range(10, 30);
                        end
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (exp_bytes_q.size() == 0) begin
                    $error("unexpected output beat: tdata %02h, tlast %0b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = exp_bytes_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("tdata: expected %02h, got %02h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("tlast: expected %0b, got %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_tready <= 1'b0;
            end else if (snk_calm > 0) begin
                snk_calm--;
                m_tready <= 1'b1;
            end else begin
                snk_stall = pick_idle();
                m_tready <= (snk_stall == 0);
                if (snk_stall > 0) begin
                    snk_stall--;
                end
                if ($urandom_range(24) == 0) begin
                    snk_calm = $urandom_range(15, 40);
                end
            end
        end
    end

    initial begin
        add_item(KIND_VALUE, 64'd0);
        add_item(KIND_VALUE, 64'd1);
        add_item(KIND_VALUE, 64'd63);
        add_item(KIND_VALUE, 64'd64);
        add_item(KIND_VALUE, 64'd127);
        add_item(KIND_VALUE, 64'd128);
        add_item(KIND_VALUE, 64'h1FFF);
        add_item(KIND_VALUE, 64'h2000);
        add_item(KIND_VALUE, 64'h3FFF);
        add_item(KIND_VALUE, 64'h00FF_FFFF_FFFF_FFFF);
        add_item(KIND_VALUE, 64'h4000_0000_0000_0000);
        add_item(KIND_VALUE, 64'h8000_0000_0000_0000);
        add_item(KIND_VALUE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(KIND_VALUE, 64'h5555_5555_5555_5555);
        add_item(KIND_VALUE, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(KIND_NOT_FOUND, 64'd0);
        add_item(KIND_INVALID, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(KIND_END_SEQ, 64'h8000_0000_0000_0001);
        add_item(KIND_NOT_FOUND, {$urandom, $urandom});
        add_item(KIND_INVALID, 64'd0);
        add_item(KIND_END_SEQ, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int n = 0; n < 350; n++) begin
            if ($urandom_range(99) < 75) begin
                add_item(KIND_VALUE, rand_value());
            end else begin
                add_item(t_kind'($urandom_range(1, 3)), {$urandom, $urandom});
            end
        end
        items_total = enc_items_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < items_total || exp_bytes_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("tb_top: %0d items accepted, %0d of them markers and %0d ten-byte values",
                 items_taken, markers_taken, ten_byte_values);
        $display("tb_top: %0d output bytes checked under random gaps and stalls", bytes_checked);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/vmbe_pkg.sv
hdl/vmbe_digit.sv
hdl/vmbe_obuf.sv
hdl/varint_marker_byte_encoder.sv
hdl/vmbe_checker.sv
tb/tb_top.sv
